@@ src/atlas_shelf_packer_macros.svh @@
// Assertion macros shared by the shelf packer modules.
// Depends on nothing; every use expects aclk and aresetn in scope.
`ifndef ATLAS_SHELF_PACKER_MACROS_SVH
`define ATLAS_SHELF_PACKER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define ASP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/asp_pkg.sv @@
// Shared types, constants and helpers for the shelf packer.
// Used by asp_front, asp_fifo, asp_back and atlas_shelf_packer.
`timescale 1ns / 1ps

package asp_pkg;

    localparam int MAX_GLYPHS  = 64;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int GLYPH_W     = 8;
    localparam int PAD_W       = 4;
    localparam int DIM_W       = 13;
    localparam int ROW_W       = 9;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;

    localparam logic [DIM_W-1:0] MAX_ATLAS  = 13'd4096;
    localparam logic [DIM_W-1:0] START_SIZE = 13'd8;
    localparam logic [DIM_W-1:0] POS_LIMIT  = 13'd8191;

    localparam logic [CFG_IDX_W-1:0] CFG_PADDING  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHADOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE = 2'd2;

    typedef struct packed {
        logic [PAD_W-1:0] padding;
        logic [PAD_W-1:0] shadow;
        logic             fit_mode;
    } asp_cfg_t;

    typedef struct packed {
        logic [GLYPH_W-1:0] width;
        logic [GLYPH_W-1:0] height;
        logic               last;
        logic               keep;
        logic [IDX_W-1:0]   slot;
    } asp_item_t;

    typedef enum logic [2:0] {
        B_LOAD,
        B_FIT_RD,
        B_FIT_EV,
        B_SIZE_RD,
        B_SIZE_EV,
        B_PLACE_RD,
        B_PLACE_EV
    } back_state_t;

    function automatic logic [DIM_W-1:0] sat13(input logic [DIM_W:0] v);
        sat13 = (v > {1'b0, POS_LIMIT}) ? POS_LIMIT : v[DIM_W-1:0];
    endfunction

endpackage

@@ src/asp_front.sv @@
// Input side of the shelf packer: accepts glyph transactions and tags each
// with its store slot and whether it fits in the store. Uses asp_pkg.
`timescale 1ns / 1ps

module asp_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [asp_pkg::GLYPH_W-1:0]  s_glyph_width,
    input  logic [asp_pkg::GLYPH_W-1:0]  s_glyph_height,
    input  logic                         s_last_glyph,
    input  logic                         q_full,
    output logic                         q_push,
    output asp_pkg::asp_item_t           q_push_item
);

    logic [asp_pkg::CNT_W-1:0] count_reg;
    logic                      keep;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;
    assign keep    = count_reg < asp_pkg::CNT_W'(asp_pkg::MAX_GLYPHS);

    always_comb begin
        q_push_item.width  = s_glyph_width;
        q_push_item.height = s_glyph_height;
        q_push_item.last   = s_last_glyph;
        q_push_item.keep   = keep;
        q_push_item.slot   = count_reg[asp_pkg::IDX_W-1:0];
    end

    // glyphs past a full store are dropped; a last glyph restarts the set
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (q_push) begin
            if (s_last_glyph) begin
                count_reg <= '0;
            end else if (keep) begin
                count_reg <= count_reg + asp_pkg::CNT_W'(1);
            end
        end
    end

endmodule

@@ src/asp_fifo.sv @@
// Short queue between the front and back of the shelf packer.
// Holds asp_pkg::asp_item_t entries; uses asp_pkg and the macro header.
`timescale 1ns / 1ps
`include "atlas_shelf_packer_macros.svh"

module asp_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  asp_pkg::asp_item_t push_item,
    output logic               full,
    output logic               q_valid,
    output asp_pkg::asp_item_t q_item,
    input  logic               pop
);

    asp_pkg::asp_item_t entry_reg [asp_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full    = count_reg == 2'(asp_pkg::QUEUE_DEPTH);
    assign q_valid = count_reg != 2'd0;
    assign q_item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    `ASP_ASSERT_IMPL(a_no_overflow, push, !full || pop, "queue written while full")
    `ASP_ASSERT_IMPL(a_no_underflow, pop, q_valid, "queue read while empty")

endmodule

@@ src/asp_back.sv @@
// Packing engine of the shelf packer: glyph store, size search and placement.
// Uses asp_pkg and the macro header; fed by asp_fifo.
`timescale 1ns / 1ps
`include "atlas_shelf_packer_macros.svh"

module asp_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  asp_pkg::asp_cfg_t          cfg,
    input  logic                       q_valid,
    input  asp_pkg::asp_item_t         q_item,
    output logic                       q_pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [asp_pkg::DIM_W-1:0]  m_pos_x,
    output logic [asp_pkg::DIM_W-1:0]  m_pos_y,
    output logic [asp_pkg::DIM_W-1:0]  m_atlas_width,
    output logic [asp_pkg::DIM_W-1:0]  m_atlas_height,
    output logic                       m_too_large,
    output logic                       m_last_place
);

    localparam int DW = asp_pkg::DIM_W;
    localparam int RW = asp_pkg::ROW_W;
    localparam int GW = asp_pkg::GLYPH_W;

    asp_pkg::back_state_t state_reg, state_next;

    logic [GW-1:0] width_mem  [asp_pkg::MAX_GLYPHS];
    logic [GW-1:0] height_mem [asp_pkg::MAX_GLYPHS];
    logic [GW-1:0] rd_w_reg, rd_h_reg;

    logic [asp_pkg::IDX_W-1:0] idx_reg;
    logic [asp_pkg::CNT_W-1:0] n_reg;
    logic [DW-1:0] size_reg, aw_reg, ah_reg, cx_reg, cy_reg;
    logic [RW-1:0] rh_reg;
    logic          big_reg;

    logic          m_valid_reg, m_too_large_reg, m_last_place_reg;
    logic [DW-1:0] m_pos_x_reg, m_pos_y_reg, m_atlas_width_reg, m_atlas_height_reg;

    logic mem_we, out_fire, idx_last;

    // sizing datapath
    logic [4:0]    pad;
    logic [5:0]    pad2;
    logic [RW-1:0] gw_s, gh_s, rh_new;
    logic [DW:0]   sum_x, y_base, x_end, y_end;
    logic          wrap_s, size_fail;
    logic [DW-1:0] fit_w, fit_h;

    // placement datapath
    logic [RW-1:0] gw_p, gh_p, rh_pn;
    logic [DW:0]   sum_p;
    logic          wrap_p;
    logic [DW-1:0] cx_b, cx_n, cy_n, px, py;

    logic in_size_ev, run_done, big_shown, pos_zero;

    assign idx_last = ({1'b0, idx_reg} + asp_pkg::CNT_W'(1)) == n_reg;

    assign pad   = {1'b0, cfg.padding} + {1'b0, cfg.shadow};
    assign pad2  = {pad, 1'b0};
    assign gw_s  = {1'b0, rd_w_reg} + RW'(pad2);
    assign gh_s  = {1'b0, rd_h_reg} + RW'(pad2);
    assign fit_w = DW'(rd_w_reg) + DW'(pad2);
    assign fit_h = DW'(rd_h_reg) + DW'(pad2);

    assign sum_x     = {1'b0, cx_reg} + (DW+1)'(gw_s);
    assign wrap_s    = sum_x > {1'b0, size_reg};
    assign y_base    = wrap_s ? ({1'b0, cy_reg} + (DW+1)'(rh_reg)) : {1'b0, cy_reg};
    assign x_end     = wrap_s ? (DW+1)'(gw_s) : sum_x;
    assign y_end     = y_base + (DW+1)'(gh_s);
    assign size_fail = (x_end > {1'b0, size_reg}) || (y_end > {1'b0, size_reg});
    assign rh_new    = (wrap_s || gh_s > rh_reg) ? gh_s : rh_reg;

    assign gw_p   = {1'b0, rd_w_reg} + RW'({cfg.padding, 1'b0}) + RW'(cfg.shadow);
    assign gh_p   = {1'b0, rd_h_reg} + RW'({cfg.padding, 1'b0}) + RW'(cfg.shadow);
    assign sum_p  = {1'b0, cx_reg} + (DW+1)'(gw_p);
    assign wrap_p = sum_p > {1'b0, aw_reg};
    assign cy_n   = wrap_p ? asp_pkg::sat13({1'b0, cy_reg} + (DW+1)'(rh_reg)) : cy_reg;
    assign cx_b   = wrap_p ? '0 : cx_reg;
    assign px     = asp_pkg::sat13({1'b0, cx_b} + (DW+1)'(cfg.padding));
    assign py     = asp_pkg::sat13({1'b0, cy_n} + (DW+1)'(cfg.padding));
    assign cx_n   = asp_pkg::sat13({1'b0, cx_b} + (DW+1)'(gw_p));
    assign rh_pn  = (wrap_p || gh_p > rh_reg) ? gh_p : rh_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            asp_pkg::B_LOAD: begin
                if (q_valid && q_item.last) begin
                    state_next = cfg.fit_mode ? asp_pkg::B_FIT_RD : asp_pkg::B_SIZE_RD;
                end
            end
            asp_pkg::B_FIT_RD:  state_next = asp_pkg::B_FIT_EV;
            asp_pkg::B_FIT_EV:  state_next = asp_pkg::B_PLACE_RD;
            asp_pkg::B_SIZE_RD: state_next = asp_pkg::B_SIZE_EV;
            asp_pkg::B_SIZE_EV: begin
                if (size_fail) begin
                    state_next = (size_reg == asp_pkg::MAX_ATLAS) ?
                                 asp_pkg::B_PLACE_RD : asp_pkg::B_SIZE_RD;
                end else if (idx_last) begin
                    state_next = asp_pkg::B_PLACE_RD;
                end else begin
                    state_next = asp_pkg::B_SIZE_RD;
                end
            end
            asp_pkg::B_PLACE_RD: state_next = asp_pkg::B_PLACE_EV;
            asp_pkg::B_PLACE_EV: begin
                if (out_fire) begin
                    state_next = idx_last ? asp_pkg::B_LOAD : asp_pkg::B_PLACE_RD;
                end
            end
            default: state_next = asp_pkg::B_LOAD;
        endcase
    end

    // state outputs
    always_comb begin
        q_pop    = 1'b0;
        mem_we   = 1'b0;
        out_fire = 1'b0;
        case (state_reg)
            asp_pkg::B_LOAD: begin
                q_pop  = q_valid;
                mem_we = q_valid && q_item.keep;
            end
            asp_pkg::B_PLACE_EV: out_fire = !m_valid_reg || m_ready;
            default: begin
                q_pop    = 1'b0;
                mem_we   = 1'b0;
                out_fire = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            width_mem[q_item.slot]  <= q_item.width;
            height_mem[q_item.slot] <= q_item.height;
        end
        rd_w_reg <= width_mem[idx_reg];
        rd_h_reg <= height_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= asp_pkg::B_LOAD;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (out_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                asp_pkg::B_LOAD: begin
                    if (q_valid && q_item.last) begin
                        idx_reg <= '0;
                    end
                end
                asp_pkg::B_SIZE_EV: begin
                    idx_reg <= (size_fail || idx_last) ? '0
                                                       : idx_reg + asp_pkg::IDX_W'(1);
                end
                asp_pkg::B_PLACE_EV: begin
                    if (out_fire) begin
                        idx_reg <= idx_reg + asp_pkg::IDX_W'(1);
                    end
                end
                default: idx_reg <= idx_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            asp_pkg::B_LOAD: begin
                if (q_valid && q_item.last) begin
                    n_reg    <= q_item.keep ?
                                (asp_pkg::CNT_W'(q_item.slot) + asp_pkg::CNT_W'(1))
                                : asp_pkg::CNT_W'(asp_pkg::MAX_GLYPHS);
                    size_reg <= asp_pkg::START_SIZE;
                    cx_reg   <= '0;
                    cy_reg   <= '0;
                    rh_reg   <= '0;
                end
            end
            asp_pkg::B_FIT_EV: begin
                aw_reg  <= fit_w;
                ah_reg  <= fit_h;
                big_reg <= (fit_w > asp_pkg::MAX_ATLAS) || (fit_h > asp_pkg::MAX_ATLAS);
            end
            asp_pkg::B_SIZE_EV: begin
                if (size_fail) begin
                    cx_reg <= '0;
                    cy_reg <= '0;
                    rh_reg <= '0;
                    if (size_reg == asp_pkg::MAX_ATLAS) begin
                        big_reg <= 1'b1;
                        aw_reg  <= asp_pkg::MAX_ATLAS;
                        ah_reg  <= asp_pkg::MAX_ATLAS;
                    end else begin
                        size_reg <= {size_reg[DW-2:0], 1'b0};
                    end
                end else if (idx_last) begin
                    big_reg <= 1'b0;
                    aw_reg  <= size_reg;
                    ah_reg  <= size_reg;
                    cx_reg  <= '0;
                    cy_reg  <= '0;
                    rh_reg  <= '0;
                end else begin
                    cx_reg <= x_end[DW-1:0];
                    cy_reg <= y_base[DW-1:0];
                    rh_reg <= rh_new;
                end
            end
            asp_pkg::B_PLACE_EV: begin
                if (out_fire) begin
                    cx_reg <= cx_n;
                    cy_reg <= cy_n;
                    rh_reg <= rh_pn;
                end
            end
            default: cx_reg <= cx_reg;
        endcase
    end

    // result register; an oversized set reports zero positions
    always_ff @(posedge aclk) begin
        if (out_fire) begin
            m_pos_x_reg        <= big_reg ? '0 : px;
            m_pos_y_reg        <= big_reg ? '0 : py;
            m_atlas_width_reg  <= aw_reg;
            m_atlas_height_reg <= ah_reg;
            m_too_large_reg    <= big_reg;
            m_last_place_reg   <= idx_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pos_x        = m_pos_x_reg;
    assign m_pos_y        = m_pos_y_reg;
    assign m_atlas_width  = m_atlas_width_reg;
    assign m_atlas_height = m_atlas_height_reg;
    assign m_too_large    = m_too_large_reg;
    assign m_last_place   = m_last_place_reg;

    assign in_size_ev = state_reg == asp_pkg::B_SIZE_EV;
    assign run_done   = out_fire && idx_last;
    assign big_shown  = m_valid_reg && m_too_large_reg;
    assign pos_zero   = (m_pos_x_reg == '0) && (m_pos_y_reg == '0);

    `ASP_ASSERT_IMPL(a_size_pow2, in_size_ev, $onehot(size_reg), "trial size not a power of two")
    `ASP_ASSERT_NEXT(a_last_ends_run, run_done, state_reg == asp_pkg::B_LOAD, "run did not end")
    `ASP_ASSERT_IMPL(a_big_zero_pos, big_shown, pos_zero, "oversized result with nonzero position")

endmodule

@@ src/atlas_shelf_packer.sv @@
// Top level of the glyph atlas shelf packer: configuration registers and
// the front, queue and back instances. Uses asp_pkg, asp_front, asp_fifo, asp_back.
`timescale 1ns / 1ps

// Glyph sizes enter through a two-entry queue on the s_ channel, one per cycle
// while the queue has room, and are kept in a 64-entry store; glyphs beyond 64
// in one set are dropped. The transaction that carries last_glyph starts packing
// the set of n glyphs, and one result per glyph leaves on the m_ channel in load
// order. The store has one read port and each glyph visit is a read step and then
// an evaluate step: fit mode makes one visit and then places all n glyphs, normal
// mode makes up to ten sizing passes (a pass ends at the first glyph that does not
// fit) before placement, and results wait while m_ready is low. New glyphs are
// taken into the queue while a set is being packed, until the queue is full.

module atlas_shelf_packer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [asp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [asp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [asp_pkg::GLYPH_W-1:0]      s_glyph_width,
    input  logic [asp_pkg::GLYPH_W-1:0]      s_glyph_height,
    input  logic                             s_last_glyph,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [asp_pkg::DIM_W-1:0]        m_pos_x,
    output logic [asp_pkg::DIM_W-1:0]        m_pos_y,
    output logic [asp_pkg::DIM_W-1:0]        m_atlas_width,
    output logic [asp_pkg::DIM_W-1:0]        m_atlas_height,
    output logic                             m_too_large,
    output logic                             m_last_place
);

    asp_pkg::asp_cfg_t  cfg_reg;
    asp_pkg::asp_item_t push_item, q_item;
    logic q_full, q_push, q_valid, q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                asp_pkg::CFG_PADDING:  cfg_reg.padding  <= cfg_wdata;
                asp_pkg::CFG_SHADOW:   cfg_reg.shadow   <= cfg_wdata;
                asp_pkg::CFG_FIT_MODE: cfg_reg.fit_mode <= cfg_wdata[0];
                default:               cfg_reg          <= cfg_reg;
            endcase
        end
    end

    asp_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_glyph_width  (s_glyph_width),
        .s_glyph_height (s_glyph_height),
        .s_last_glyph   (s_last_glyph),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_push_item    (push_item)
    );

    asp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (q_pop)
    );

    asp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pos_x        (m_pos_x),
        .m_pos_y        (m_pos_y),
        .m_atlas_width  (m_atlas_width),
        .m_atlas_height (m_atlas_height),
        .m_too_large    (m_too_large),
        .m_last_place   (m_last_place)
    );

endmodule
